// ===== hw/rtl/monotone_cubic_hermite_interpolator_top_defines.svh =====
// Assertion macros shared by the interpolator RTL.
`ifndef MONOTONE_CUBIC_HERMITE_INTERPOLATOR_TOP_DEFINES_SVH
`define MONOTONE_CUBIC_HERMITE_INTERPOLATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked while the block is out of reset.
`define MCHI_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define MCHI_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCHI_ASSERT(name, prop, msg)
`define MCHI_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ===== hw/rtl/mchi_pkg.sv =====
// Types and constants shared by the interpolator modules.
package mchi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int CNT_W     = 7;
	localparam int IDX_W     = 6;
	localparam int T_W       = FRAC_BITS + 1;
	localparam int BAS_W     = FRAC_BITS + 4;
	localparam int DIV_N_W   = DATA_W + FRAC_BITS;
	localparam int DIV_D_W   = DATA_W;
	localparam int MUL_W     = 40;
	localparam int MUL_DIG   = 8;
	localparam int PROD_W    = 64;

	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_SLOPES = 2'd1;
	localparam logic [1:0] CMD_EVAL   = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_BELOW = 2'd1;
	localparam logic [1:0] STS_ABOVE = 2'd2;
	localparam logic [1:0] STS_RANGE = 2'd3;

	typedef struct packed {
		logic [1:0]                command;
		logic [IDX_W-1:0]          knot_index;
		logic signed [DATA_W-1:0]  abscissa;
		logic signed [DATA_W-1:0]  ordinate;
		logic signed [DATA_W-1:0]  slope_in;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  value;
		logic [IDX_W-1:0]          segment;
		logic [1:0]                status;
	} out_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  x;
		logic signed [DATA_W-1:0]  y;
		logic signed [DATA_W-1:0]  m;
	} knot_t;

	typedef struct packed {
		logic                  start;
		logic [DIV_N_W-1:0]    dividend;
		logic [DIV_D_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIV_N_W-1:0]    quot;
	} div_rsp_t;

	typedef struct packed {
		logic                     start;
		logic signed [MUL_W-1:0]  a;
		logic signed [MUL_W-1:0]  b;
	} mul_req_t;

	typedef struct packed {
		logic                      done;
		logic signed [PROD_W-1:0]  prod;
	} mul_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_WRITE,
		S_FIN,
		S_SL_RD0,
		S_SL_LD0,
		S_SL_RD,
		S_SL_DATA,
		S_SL_DIV,
		S_SL_WR,
		S_SL_LAST,
		S_EV_RD0,
		S_EV_CK0,
		S_EV_CKN,
		S_EV_SRCH,
		S_EV_CMP,
		S_EV_HI,
		S_EV_LAST,
		S_EV_L,
		S_EV_R,
		S_EV_DIV,
		S_MUL_GO,
		S_MUL_WAIT
	} ctrl_state_t;

endpackage

// ===== hw/rtl/monotone_cubic_hermite_interpolator_top.sv =====
// Top level of the monotone cubic Hermite interpolator.
//
// The block takes one command beat at a time on the input channel (in_valid,
// in_stall, in_data) and returns exactly one result beat per command on the
// output channel (out_valid, out_stall, out_data). Command 0 stores one knot,
// command 1 rewrites the slopes of the knots in use from their secants, and
// command 2 searches the segment that holds the query and evaluates the cubic.
// The knot count is written through cfg_wen and cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Knots live in one single-port memory whose read data comes back registered,
// so the sequencer works on one command at a time and in_stall stays high until
// its result moves to the output register. Slope derivation runs the divider
// once per secant (a zero-width step skips it); a query uses the divider for t
// and 8 multiplies on the byte-serial multiplier.
// Reset clears the sequencer state and out_valid and sets the knot count to
// two; the knot memory is not cleared and must be written before it is read.
// When the receiver stalls, the result waits in the output register and the
// block still accepts and works on the next command; that command finishes
// only when the output register has drained.
module monotone_cubic_hermite_interpolator_top #(
	parameter int MAX_KNOTS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mchi_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mchi_pkg::out_item_t  out_data,
	input  logic                 cfg_wen,
	input  logic [6:0]           cfg_wdata
);
	import mchi_pkg::*;

	`include "monotone_cubic_hermite_interpolator_top_defines.svh"

	localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
	localparam int NW = $clog2(MAX_KNOTS + 1);

	logic [CNT_W-1:0] knot_count_q;
	logic [NW-1:0]    n_eff;
	logic             accept;
	logic             busy;
	logic             res_valid;
	logic             res_ready;
	out_item_t        res;
	logic             out_valid_q;
	out_item_t        out_data_q;

	logic             mem_we;
	logic [AW-1:0]    mem_addr;
	knot_t            mem_wdata;
	knot_t            mem_rdata;
	div_req_t         div_req;
	div_rsp_t         div_rsp;
	mul_req_t         mul_req;
	mul_rsp_t         mul_rsp;

	// Knot count register; the sequencer sees it clamped to [2, MAX_KNOTS].
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knot_count_q <= CNT_W'(2);
		end else if (cfg_wen) begin
			knot_count_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (int'(knot_count_q) < 2) begin
			n_eff = NW'(2);
		end else if (int'(knot_count_q) > MAX_KNOTS) begin
			n_eff = NW'(MAX_KNOTS);
		end else begin
			n_eff = NW'(knot_count_q);
		end
	end

	assign in_stall  = busy;
	assign accept    = in_valid && !in_stall;
	assign res_ready = !out_valid_q || !out_stall;

	// Output register: the sequencer hands over a result whenever it is empty or
	// being drained in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	mchi_mem #(
		.DEPTH (MAX_KNOTS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	mchi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	mchi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	mchi_ctrl #(
		.MAX_KNOTS (MAX_KNOTS),
		.AW        (AW),
		.NW        (NW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.item      (in_data),
		.n_eff     (n_eff),
		.busy      (busy),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.mul_req   (mul_req),
		.mul_rsp   (mul_rsp)
	);

	`MCHI_ASSERT(a_accept_then_busy, (in_valid && !in_stall) |=> in_stall, "command accepted but block not busy")
	`MCHI_ASSERT(a_count_clamped, (int'(n_eff) >= 2) && (int'(n_eff) <= MAX_KNOTS), "knot count out of range")
	`MCHI_ASSERT(a_result_needs_work, $rose(out_valid) |-> $past(busy), "result beat without a command")
	`MCHI_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "result beat during reset")

endmodule

// ===== hw/rtl/mchi_mem.sv =====
// Knot table: single-port synchronous memory with registered read data.
module mchi_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      addr,
	input  mchi_pkg::knot_t    wdata,
	output mchi_pkg::knot_t    rdata
);
	import mchi_pkg::*;

	knot_t mem [DEPTH];
	knot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/mchi_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
module mchi_div (
	input  logic                clk,
	input  logic                arst_n,
	input  mchi_pkg::div_req_t  req,
	output mchi_pkg::div_rsp_t  rsp
);
	import mchi_pkg::*;

	localparam int STEPS = DIV_N_W;
	localparam int CW    = $clog2(STEPS);

	logic               busy_q;
	logic               done_q;
	logic [CW-1:0]      cnt_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_N_W-1:0] quo_q;
	logic [DIV_D_W-1:0] den_q;

	logic [DIV_D_W:0]   rem_sh;
	logic [DIV_D_W:0]   diff;
	logic               ge;

	always_comb begin
		rem_sh = {rem_q, quo_q[DIV_N_W-1]};
		diff   = rem_sh - {1'b0, den_q};
		ge     = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// ===== hw/rtl/mchi_mul.sv =====
// Signed multiplier, one byte of the multiplier per cycle; the product is divided
// by 2^FRAC_BITS with truncation toward zero.
module mchi_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  mchi_pkg::mul_req_t  req,
	output mchi_pkg::mul_rsp_t  rsp
);
	import mchi_pkg::*;

	localparam int STEPS = MUL_W / MUL_DIG;
	localparam int CW    = $clog2(STEPS + 1);
	localparam int ACC_W = 2 * MUL_W;

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic              neg_q;
	logic [ACC_W-1:0]  mcand_q;
	logic [MUL_W-1:0]  mplier_q;
	logic [ACC_W-1:0]  acc_q;

	logic [MUL_W-1:0]  a_mag;
	logic [MUL_W-1:0]  b_mag;
	logic [ACC_W-1:0]  partial;
	logic [PROD_W-1:0] mag;

	always_comb begin
		a_mag   = req.a[MUL_W-1] ? MUL_W'(-req.a) : MUL_W'(req.a);
		b_mag   = req.b[MUL_W-1] ? MUL_W'(-req.b) : MUL_W'(req.b);
		partial = mcand_q * ACC_W'(mplier_q[MUL_DIG-1:0]);
		mag     = acc_q[FRAC_BITS +: PROD_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q    <= req.a[MUL_W-1] ^ req.b[MUL_W-1];
			mcand_q  <= ACC_W'(a_mag);
			mplier_q <= b_mag;
			acc_q    <= '0;
		end else if (busy_q) begin
			acc_q    <= acc_q + partial;
			mcand_q  <= mcand_q << MUL_DIG;
			mplier_q <= mplier_q >> MUL_DIG;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = neg_q ? -$signed(mag) : $signed(mag);

endmodule

// ===== hw/rtl/mchi_ctrl.sv =====
// Command sequencer: knot writes, slope derivation and segment search with Hermite
// evaluation, all through the knot memory port.
module mchi_ctrl #(
	parameter int MAX_KNOTS = 64,
	parameter int AW        = 6,
	parameter int NW        = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  mchi_pkg::in_item_t   item,
	input  logic [NW-1:0]        n_eff,
	output logic                 busy,
	output logic                 res_valid,
	input  logic                 res_ready,
	output mchi_pkg::out_item_t  res,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_addr,
	output mchi_pkg::knot_t      mem_wdata,
	input  mchi_pkg::knot_t      mem_rdata,
	output mchi_pkg::div_req_t   div_req,
	input  mchi_pkg::div_rsp_t   div_rsp,
	output mchi_pkg::mul_req_t   mul_req,
	input  mchi_pkg::mul_rsp_t   mul_rsp
);
	import mchi_pkg::*;

	localparam logic [2:0] OP_T2  = 3'd0;
	localparam logic [2:0] OP_T3  = 3'd1;
	localparam logic [2:0] OP_Y0  = 3'd2;
	localparam logic [2:0] OP_H10 = 3'd3;
	localparam logic [2:0] OP_M0  = 3'd4;
	localparam logic [2:0] OP_Y1  = 3'd5;
	localparam logic [2:0] OP_H11 = 3'd6;
	localparam logic [2:0] OP_M1  = 3'd7;
	localparam int ACC_W = PROD_W + 2;
	localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'(64'sh7fffffff);
	localparam logic signed [ACC_W-1:0] SUM_MIN = ACC_W'(-64'sh80000000);

	ctrl_state_t state_q, state_d;

	logic [IDX_W-1:0]          kidx_q;
	logic signed [DATA_W-1:0]  q_q, yin_q, min_q;
	logic [AW-1:0]             i_q, lo_q, hi_q, mid_q, idx_q;
	logic signed [DATA_W-1:0]  x0_q, y0_q, m0_q, x1_q, y1_q, m1_q;
	logic signed [DATA_W:0]    h_q;
	logic signed [DATA_W-1:0]  sec_q, prev_q;
	logic                      neg_q;
	logic [T_W-1:0]            t_q, t2_q, t3_q;
	logic signed [MUL_W-1:0]   tmp_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [2:0]                k_q;
	out_item_t                 res_q;

	logic [AW-1:0]             n_last;
	logic [AW-1:0]             mid;
	logic [AW:0]               mid_sum;
	logic                      kidx_ok;
	logic                      mid_le;
	logic signed [DATA_W:0]    dx, dy, h_now, q_off;
	logic                      h_pos;
	logic [DATA_W-1:0]         dx_mag, dy_mag;
	logic signed [DATA_W:0]    pair_sum, pair_adj;
	logic signed [DATA_W-1:0]  slope_i, sec_sat;
	logic signed [BAS_W-1:0]   tt, t2s, t3s, b00, b10, b01, b11;
	logic signed [ACC_W-1:0]   sum_next;
	logic signed [DATA_W-1:0]  sum_sat;

	function automatic logic signed [DATA_W-1:0] sat_quot(input logic [DIV_N_W-1:0] qv,
			input logic neg);
		logic [DIV_N_W-1:0] lim;
		begin
			lim = DIV_N_W'({1'b1, {(DATA_W-1){1'b0}}});
			if (neg) begin
				sat_quot = (qv > lim) ? {1'b1, {(DATA_W-1){1'b0}}} : -DATA_W'(qv);
			end else begin
				sat_quot = (qv >= lim) ? {1'b0, {(DATA_W-1){1'b1}}} : DATA_W'(qv);
			end
		end
	endfunction

	always_comb begin
		n_last   = AW'(n_eff - NW'(1));
		mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
		mid      = mid_sum[AW:1];
		kidx_ok  = int'(kidx_q) < MAX_KNOTS;
		mid_le   = mem_rdata.x <= q_q;
		dx       = (DATA_W+1)'(mem_rdata.x) - (DATA_W+1)'(x0_q);
		dy       = (DATA_W+1)'(mem_rdata.y) - (DATA_W+1)'(y0_q);
		h_now    = dx;
		h_pos    = !h_now[DATA_W] && (h_now != '0);
		q_off    = (DATA_W+1)'(q_q) - (DATA_W+1)'(x0_q);
		dx_mag   = dx[DATA_W] ? DATA_W'(-dx) : DATA_W'(dx);
		dy_mag   = dy[DATA_W] ? DATA_W'(-dy) : DATA_W'(dy);
		sec_sat  = sat_quot(div_rsp.quot, neg_q);
		// Mean of the two secants, rounded toward zero.
		pair_sum = (DATA_W+1)'(prev_q) + (DATA_W+1)'(sec_q);
		pair_adj = pair_sum + (DATA_W+1)'(pair_sum[DATA_W]);
		if (i_q == '0) begin
			slope_i = sec_q;
		end else if (prev_q == '0 || sec_q == '0) begin
			slope_i = '0;
		end else begin
			slope_i = pair_adj[DATA_W:1];
		end
		// Hermite basis from t, t^2 and t^3.
		tt  = BAS_W'($signed({1'b0, t_q}));
		t2s = BAS_W'($signed({1'b0, t2_q}));
		t3s = BAS_W'($signed({1'b0, t3_q}));
		b00 = (t3s <<< 1) - (t2s + (t2s <<< 1)) + BAS_W'(1 << FRAC_BITS);
		b10 = t3s - (t2s <<< 1) + tt;
		b01 = (t2s + (t2s <<< 1)) - (t3s <<< 1);
		b11 = t3s - t2s;
		sum_next = acc_q + ACC_W'(mul_rsp.prod);
		if (sum_next > SUM_MAX) begin
			sum_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (sum_next < SUM_MIN) begin
			sum_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sum_sat = DATA_W'(sum_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '{x: x0_q, y: y0_q, m: slope_i};
		div_req   = '0;
		mul_req   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (item.command)
						CMD_WRITE:  state_d = S_WRITE;
						CMD_SLOPES: state_d = S_SL_RD0;
						CMD_EVAL:   state_d = S_EV_RD0;
						default:    state_d = S_FIN;
					endcase
				end
			end
			S_WRITE: begin
				mem_we    = kidx_ok;
				mem_addr  = AW'(kidx_q);
				mem_wdata = '{x: q_q, y: yin_q, m: min_q};
				state_d   = S_FIN;
			end
			S_FIN: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			S_SL_RD0: begin
				state_d = S_SL_LD0;
			end
			S_SL_LD0: begin
				state_d = S_SL_RD;
			end
			S_SL_RD: begin
				mem_addr = i_q + 1'b1;
				state_d  = S_SL_DATA;
			end
			S_SL_DATA: begin
				if (dx == '0) begin
					state_d = S_SL_WR;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = {dy_mag, {FRAC_BITS{1'b0}}};
					div_req.divisor  = dx_mag;
					state_d          = S_SL_DIV;
				end
			end
			S_SL_DIV: begin
				if (div_rsp.done) begin
					state_d = S_SL_WR;
				end
			end
			S_SL_WR: begin
				mem_we   = 1'b1;
				mem_addr = i_q;
				state_d  = ((i_q + 1'b1) == n_last) ? S_SL_LAST : S_SL_RD;
			end
			S_SL_LAST: begin
				mem_we    = 1'b1;
				mem_addr  = n_last;
				mem_wdata = '{x: x0_q, y: y0_q, m: prev_q};
				state_d   = S_FIN;
			end
			S_EV_RD0: begin
				state_d = S_EV_CK0;
			end
			S_EV_CK0: begin
				mem_addr = n_last;
				state_d  = (q_q < mem_rdata.x) ? S_FIN : S_EV_CKN;
			end
			S_EV_CKN: begin
				state_d = (q_q > mem_rdata.x) ? S_FIN : S_EV_SRCH;
			end
			S_EV_SRCH: begin
				if ((hi_q - lo_q) > AW'(1)) begin
					mem_addr = mid;
					state_d  = S_EV_CMP;
				end else begin
					mem_addr = hi_q;
					state_d  = S_EV_HI;
				end
			end
			S_EV_CMP: begin
				state_d = S_EV_SRCH;
			end
			S_EV_HI: begin
				if (mid_le) begin
					mem_addr = hi_q;
					state_d  = (hi_q == n_last) ? S_EV_LAST : S_EV_L;
				end else begin
					mem_addr = lo_q;
					state_d  = S_EV_L;
				end
			end
			S_EV_LAST: begin
				state_d = S_FIN;
			end
			S_EV_L: begin
				mem_addr = idx_q + 1'b1;
				state_d  = S_EV_R;
			end
			S_EV_R: begin
				if (h_pos) begin
					div_req.start    = 1'b1;
					div_req.dividend = {q_off[DATA_W-1:0], {FRAC_BITS{1'b0}}};
					div_req.divisor  = h_now[DATA_W-1:0];
					state_d          = S_EV_DIV;
				end else begin
					state_d = S_FIN;
				end
			end
			S_EV_DIV: begin
				if (div_rsp.done) begin
					state_d = S_MUL_GO;
				end
			end
			S_MUL_GO: begin
				mul_req.start = 1'b1;
				case (k_q)
					OP_T2: begin
						mul_req.a = MUL_W'($signed({1'b0, t_q}));
						mul_req.b = MUL_W'($signed({1'b0, t_q}));
					end
					OP_T3: begin
						mul_req.a = MUL_W'($signed({1'b0, t2_q}));
						mul_req.b = MUL_W'($signed({1'b0, t_q}));
					end
					OP_Y0: begin
						mul_req.a = MUL_W'(b00);
						mul_req.b = MUL_W'(y0_q);
					end
					OP_H10: begin
						mul_req.a = MUL_W'(b10);
						mul_req.b = MUL_W'(h_q);
					end
					OP_M0: begin
						mul_req.a = tmp_q;
						mul_req.b = MUL_W'(m0_q);
					end
					OP_Y1: begin
						mul_req.a = MUL_W'(b01);
						mul_req.b = MUL_W'(y1_q);
					end
					OP_H11: begin
						mul_req.a = MUL_W'(b11);
						mul_req.b = MUL_W'(h_q);
					end
					default: begin
						mul_req.a = tmp_q;
						mul_req.b = MUL_W'(m1_q);
					end
				endcase
				state_d = S_MUL_WAIT;
			end
			S_MUL_WAIT: begin
				if (mul_rsp.done) begin
					state_d = (k_q == OP_M1) ? S_FIN : S_MUL_GO;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					kidx_q        <= item.knot_index;
					q_q           <= item.abscissa;
					yin_q         <= item.ordinate;
					min_q         <= item.slope_in;
					res_q.value   <= '0;
					res_q.segment <= '0;
					res_q.status  <= (item.command == CMD_WRITE ||
							item.command == CMD_SLOPES ||
							item.command == CMD_EVAL) ? STS_OK : STS_RANGE;
				end
			end
			S_WRITE: begin
				res_q.segment <= kidx_q;
				res_q.status  <= (int'(kidx_q) >= int'(n_eff)) ? STS_RANGE : STS_OK;
			end
			S_SL_LD0: begin
				x0_q <= mem_rdata.x;
				y0_q <= mem_rdata.y;
				i_q  <= '0;
			end
			S_SL_DATA: begin
				x1_q  <= mem_rdata.x;
				y1_q  <= mem_rdata.y;
				neg_q <= dx[DATA_W] ^ dy[DATA_W];
				if (dx == '0) begin
					sec_q <= '0;
				end
			end
			S_SL_DIV: begin
				if (div_rsp.done) begin
					sec_q <= sec_sat;
				end
			end
			S_SL_WR: begin
				prev_q <= sec_q;
				x0_q   <= x1_q;
				y0_q   <= y1_q;
				i_q    <= i_q + 1'b1;
			end
			S_EV_CK0: begin
				if (q_q < mem_rdata.x) begin
					res_q.status <= STS_BELOW;
				end
			end
			S_EV_CKN: begin
				if (q_q > mem_rdata.x) begin
					res_q.status <= STS_ABOVE;
				end
				lo_q <= '0;
				hi_q <= n_last;
			end
			S_EV_SRCH: begin
				mid_q <= mid;
			end
			S_EV_CMP: begin
				if (mid_le) begin
					lo_q <= mid_q;
				end else begin
					hi_q <= mid_q;
				end
			end
			S_EV_HI: begin
				idx_q         <= mid_le ? hi_q : lo_q;
				res_q.segment <= IDX_W'(mid_le ? hi_q : lo_q);
			end
			S_EV_LAST: begin
				res_q.value <= mem_rdata.y;
			end
			S_EV_L: begin
				x0_q <= mem_rdata.x;
				y0_q <= mem_rdata.y;
				m0_q <= mem_rdata.m;
			end
			S_EV_R: begin
				x1_q <= mem_rdata.x;
				y1_q <= mem_rdata.y;
				m1_q <= mem_rdata.m;
				h_q  <= h_now;
				if (!h_pos) begin
					res_q.value <= y0_q;
				end
			end
			S_EV_DIV: begin
				if (div_rsp.done) begin
					t_q   <= div_rsp.quot[T_W-1:0];
					k_q   <= OP_T2;
					acc_q <= '0;
				end
			end
			S_MUL_WAIT: begin
				if (mul_rsp.done) begin
					k_q <= k_q + 1'b1;
					case (k_q)
						OP_T2:   t2_q  <= mul_rsp.prod[T_W-1:0];
						OP_T3:   t3_q  <= mul_rsp.prod[T_W-1:0];
						OP_H10:  tmp_q <= mul_rsp.prod[MUL_W-1:0];
						OP_H11:  tmp_q <= mul_rsp.prod[MUL_W-1:0];
						OP_M1:   res_q.value <= sum_sat;
						default: acc_q <= sum_next;
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res       = res_q;

endmodule

// ===== test/monotone_cubic_hermite_interpolator_top_tb.sv =====
// Self-checking testbench for the monotone cubic Hermite interpolator top level.
module monotone_cubic_hermite_interpolator_top_tb;
	import mchi_pkg::*;

	// Command code 3 is undefined and must come back flagged as out of range.
	localparam logic [1:0] CMD_UNDEFINED = 2'd3;
	localparam int         KNOTS         = 64;
	localparam longint     ONE           = 64'sd1 <<< FRAC_BITS;
	localparam longint     S32_MIN       = -64'sd2147483648;
	localparam longint     S32_MAX       = 64'sd2147483647;
	localparam int         CYCLE_LIMIT   = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_wen = 1'b0;
	logic [6:0]  cfg_wdata = '0;

	// Shadow copy of the block: knot count register and the three knot stores.
	logic [6:0]          knot_count;
	logic signed [31:0]  kx [KNOTS];
	logic signed [31:0]  ky [KNOTS];
	logic signed [31:0]  km [KNOTS];

	// Results predicted for accepted command beats, oldest first.
	out_item_t  interp_expect [$];
	int         mismatches = 0;
	int         cycles = 0;
	int         idle_pct = 0;
	int         stall_pct = 0;
	int         hold_left = 0;
	logic       hold_kick = 1'b0;

	monotone_cubic_hermite_interpolator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("monotone_cubic_hermite_interpolator_top_tb failed");
			$finish;
		end
	end

	// The long receiver hold-off runs on its own counter so that the sender
	// keeps offering beats while the output side refuses everything.
	always @(posedge clk) begin
		if (hold_kick)
			hold_left <= 2500;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// Receiver stall, random at the rate of the current phase.
	always @(posedge clk) begin
		out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
	end

	function automatic longint clip32(longint v);
		if (v > S32_MAX) return S32_MAX;
		if (v < S32_MIN) return S32_MIN;
		return v;
	endfunction

	function automatic int used_knots();
		if (knot_count < 2) return 2;
		if (knot_count > KNOTS) return KNOTS;
		return int'(knot_count);
	endfunction

	// Secant slopes, then interior means, end secants and zero on flat segments.
	function automatic void derive_monotone_slopes();
		int      n;
		longint  dx, dy;
		longint  sec [KNOTS];
		n = used_knots();
		for (int i = 0; i < n - 1; i++) begin
			dx = longint'(kx[i+1]) - longint'(kx[i]);
			dy = longint'(ky[i+1]) - longint'(ky[i]);
			sec[i] = (dx == 0) ? 0 : clip32((dy * ONE) / dx);
		end
		for (int i = 1; i < n - 1; i++)
			km[i] = (sec[i-1] + sec[i]) / 2;
		km[0] = sec[0];
		km[n-1] = sec[n-2];
		for (int i = 0; i < n - 1; i++) begin
			if (sec[i] == 0) begin
				km[i] = 0;
				km[i+1] = 0;
			end
		end
	endfunction

	function automatic longint hermite_value(int i, longint q);
		longint h, t, t2, t3, b00, b10, b01, b11, sum;
		h = longint'(kx[i+1]) - longint'(kx[i]);
		if (h <= 0) return longint'(ky[i]);
		t = ((q - longint'(kx[i])) * ONE) / h;
		t2 = (t * t) / ONE;
		t3 = (t2 * t) / ONE;
		b00 = 2 * t3 - 3 * t2 + ONE;
		b10 = t3 - 2 * t2 + t;
		b01 = 3 * t2 - 2 * t3;
		b11 = t3 - t2;
		sum = (b00 * longint'(ky[i])) / ONE;
		sum += (((b10 * h) / ONE) * longint'(km[i])) / ONE;
		sum += (b01 * longint'(ky[i+1])) / ONE;
		sum += (((b11 * h) / ONE) * longint'(km[i+1])) / ONE;
		return clip32(sum);
	endfunction

	// Applies one command to the shadow state and returns the result it causes.
	function automatic out_item_t interp_predict(in_item_t it);
		out_item_t  r;
		int         n, lo, hi, mid, idx;
		longint     q;
		r = '0;
		n = used_knots();
		q = longint'(it.abscissa);
		case (it.command)
			CMD_WRITE: begin
				kx[it.knot_index] = it.abscissa;
				ky[it.knot_index] = it.ordinate;
				km[it.knot_index] = it.slope_in;
				r.segment = it.knot_index;
				r.status = (int'(it.knot_index) >= n) ? STS_RANGE : STS_OK;
			end
			CMD_SLOPES: derive_monotone_slopes();
			CMD_EVAL: begin
				if (q < longint'(kx[0])) begin
					r.status = STS_BELOW;
				end else if (q > longint'(kx[n-1])) begin
					r.status = STS_ABOVE;
				end else begin
					lo = 0;
					hi = n - 1;
					while (hi - lo > 1) begin
						mid = lo + (hi - lo) / 2;
						if (longint'(kx[mid]) <= q) lo = mid;
						else hi = mid;
					end
					idx = (longint'(kx[hi]) <= q) ? hi : lo;
					if (idx == n - 1) r.value = ky[n-1];
					else r.value = hermite_value(idx, q);
					r.segment = idx;
				end
			end
			default: r.status = STS_RANGE;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("[%0d] mismatch on %s: got %0d, expected %0d", cycles, what, got, want);
	endtask

	// Every accepted result beat is checked against the oldest prediction.
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (interp_expect.size() == 0) begin
				report_mismatch("unexpected result beat", out_data.status, -1);
			end else begin
				e = interp_expect.pop_front();
				if (out_data.value !== e.value)
					report_mismatch("value", out_data.value, e.value);
				if (out_data.segment !== e.segment)
					report_mismatch("segment", out_data.segment, e.segment);
				if (out_data.status !== e.status)
					report_mismatch("status", out_data.status, e.status);
			end
		end
	end

	function automatic in_item_t make_beat(logic [1:0] cmd, int idx, longint x, longint y,
			longint m);
		in_item_t it;
		it.command = cmd;
		it.knot_index = idx[5:0];
		it.abscissa = x[31:0];
		it.ordinate = y[31:0];
		it.slope_in = m[31:0];
		return it;
	endfunction

	// Random value in [0, span) for spans up to 2^33.
	function automatic longint rand_below(longint span);
		longint r;
		r = longint'({1'b0, $urandom_range(32'h7fffffff), $urandom});
		return (span <= 1) ? 0 : r % span;
	endfunction

	// Sends one command beat, predicts it at acceptance, then maybe idles.
	task automatic send_beat(in_item_t it);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		interp_expect.push_back(interp_predict(it));
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// The count register is only written once every result has come back.
	task automatic set_knot_count(int v);
		in_valid <= 1'b0;
		while (interp_expect.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v[6:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		knot_count = v[6:0];
	endtask

	// Loads all knots in use with non-decreasing abscissae at a random scale;
	// a step of zero now and then makes a repeated abscissa.
	task automatic load_knots();
		int      n, mode;
		longint  step_max, x, step, y;
		n = used_knots();
		mode = $urandom_range(3);
		case (mode)
			0: step_max = 16;
			1: step_max = ONE;
			2: step_max = 64'sd1 <<< 24;
			default: step_max = (64'sd4294967295) / (n - 1);
		endcase
		x = S32_MIN + rand_below(64'sd4294967296 - (n - 1) * step_max);
		y = $signed($urandom);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(1)) y = $signed($urandom);
			else y = clip32(y + $signed($urandom_range(65535)) - 16384);
			send_beat(make_beat(CMD_WRITE, i, x, y,
				$urandom_range(3) == 0 ? 0 : $signed($urandom)));
			step = ($urandom_range(19) == 0) ? 0 : 1 + rand_below(step_max);
			x += step;
		end
	endtask

	function automatic longint pick_query();
		int      n;
		longint  x0, xn;
		n = used_knots();
		x0 = longint'(kx[0]);
		xn = longint'(kx[n-1]);
		case ($urandom_range(9))
			0: return longint'(kx[$urandom_range(n - 1)]);
			1: return (x0 > S32_MIN) ? x0 - 1 : x0;
			2: return (xn < S32_MAX) ? xn + 1 : xn;
			3: return $signed($urandom);
			default: return x0 + rand_below(xn - x0 + 1);
		endcase
	endfunction

	// Two knots at the far ends of the number range, under the reset count.
	task automatic test_reset_count_extremes();
		send_beat(make_beat(CMD_WRITE, 0, S32_MIN, S32_MAX, S32_MIN));
		send_beat(make_beat(CMD_WRITE, 1, S32_MAX, S32_MIN, S32_MAX));
		send_beat(make_beat(CMD_EVAL, 0, S32_MIN, 0, 0));
		send_beat(make_beat(CMD_EVAL, 0, S32_MAX, 0, 0));
		send_beat(make_beat(CMD_EVAL, 0, 0, 0, 0));
		send_beat(make_beat(CMD_SLOPES, 0, 0, 0, 0));
		send_beat(make_beat(CMD_EVAL, 63, -1, -1, -1));
		send_beat(make_beat(CMD_WRITE, 63, -1, -1, -1));
		send_beat(make_beat(CMD_WRITE, 2, 0, 0, 0));
		send_beat(make_beat(CMD_UNDEFINED, 63, -1, -1, -1));
		send_beat(make_beat(CMD_EVAL, 0, 64'sd12345678, 0, 0));
	endtask

	// Count written below and above its legal range, a repeated abscissa that
	// gives a zero-width step, and a flat segment whose slopes must drop to zero.
	task automatic test_flat_and_repeated();
		set_knot_count(0);
		send_beat(make_beat(CMD_WRITE, 0, -ONE, 5 * ONE, ONE));
		send_beat(make_beat(CMD_WRITE, 1, 3 * ONE, 5 * ONE, -ONE));
		send_beat(make_beat(CMD_SLOPES, 0, 0, 0, 0));
		send_beat(make_beat(CMD_EVAL, 0, ONE, 0, 0));
		set_knot_count(4);
		send_beat(make_beat(CMD_WRITE, 2, 3 * ONE, 9 * ONE, 0));
		send_beat(make_beat(CMD_WRITE, 3, 7 * ONE, 2 * ONE, 0));
		send_beat(make_beat(CMD_SLOPES, 0, 0, 0, 0));
		send_beat(make_beat(CMD_EVAL, 0, 3 * ONE, 0, 0));
		send_beat(make_beat(CMD_EVAL, 0, 5 * ONE + 17, 0, 0));
		send_beat(make_beat(CMD_EVAL, 0, 7 * ONE, 0, 0));
		set_knot_count(127);
		load_knots();
		send_beat(make_beat(CMD_SLOPES, 0, 0, 0, 0));
		send_beat(make_beat(CMD_EVAL, 0, pick_query(), 0, 0));
		send_beat(make_beat(CMD_EVAL, 0, kx[63], 0, 0));
		set_knot_count(1);
		send_beat(make_beat(CMD_EVAL, 0, kx[1], 0, 0));
	endtask

	// One random phase: a fresh count and knot set, then mostly queries mixed
	// with slope passes, in-order knot rewrites, stray writes and bad commands.
	task automatic test_random_phase(int sender_idle, int receiver_stall, int beats);
		int      n, k, sent;
		longint  lo, hi;
		idle_pct = sender_idle;
		stall_pct = receiver_stall;
		case ($urandom_range(4))
			0: set_knot_count(2);
			1: set_knot_count(64);
			default: set_knot_count($urandom_range(3, 12));
		endcase
		n = used_knots();
		load_knots();
		sent = n;
		while (sent < beats) begin
			k = $urandom_range(99);
			if (k < 60) begin
				send_beat(make_beat(CMD_EVAL, $urandom, pick_query(), $signed($urandom),
					$signed($urandom)));
			end else if (k < 66) begin
				if (n <= 16 || $urandom_range(9) == 0)
					send_beat(make_beat(CMD_SLOPES, $urandom, $signed($urandom),
						$signed($urandom), $signed($urandom)));
			end else if (k < 74) begin
				send_beat(make_beat(CMD_WRITE, $urandom_range(KNOTS - 1), $signed($urandom),
					$signed($urandom), $signed($urandom)));
				// A stray write inside the count may break the order; reload then.
				if (int'(in_data.knot_index) < n) begin
					load_knots();
					sent += n;
				end
			end else if (k < 80) begin
				send_beat(make_beat(CMD_UNDEFINED, $urandom, $signed($urandom),
					$signed($urandom), $signed($urandom)));
			end else if (k < 96) begin
				k = $urandom_range(n - 1);
				lo = (k > 0) ? longint'(kx[k-1]) : S32_MIN;
				hi = (k < n - 1) ? longint'(kx[k+1]) : S32_MAX;
				send_beat(make_beat(CMD_WRITE, k, lo + rand_below(hi - lo + 1),
					$signed($urandom), $signed($urandom)));
			end else begin
				load_knots();
				sent += n;
			end
			sent++;
		end
	endtask

	// The receiver refuses results for a long stretch while the sender keeps
	// offering queries without gaps, so the block backs up and stalls its input.
	task automatic test_output_hold();
		idle_pct = 0;
		stall_pct = 0;
		hold_kick <= 1'b1;
		@(posedge clk);
		hold_kick <= 1'b0;
		repeat (8)
			send_beat(make_beat(CMD_EVAL, 0, pick_query(), 0, 0));
	endtask

	initial begin
		knot_count = 7'd2;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_count_extremes();
		test_flat_and_repeated();
		test_random_phase(0, 0, 340);
		test_random_phase(72, 0, 340);
		test_random_phase(0, 72, 340);
		test_random_phase(30, 30, 340);
		test_output_hold();
		in_valid <= 1'b0;
		while (interp_expect.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("monotone_cubic_hermite_interpolator_top_tb passed");
		else
			$display("monotone_cubic_hermite_interpolator_top_tb failed");
		$finish;
	end

endmodule
